// File: src/sci_pkg.sv
// Shared constants and types of the segment and circle crossing block.
`timescale 1ns / 1ps

package sci_pkg;

  // Default coordinate width in bits.
  localparam int COORD_BITS_DEF = 16;

  // Cross products at or above two to this power never yield a crossing.
  localparam int CROSS_LIMIT_BITS = 32;

  // Decision flags that travel with an item from the front end through the square root unit.
  typedef struct packed {
    logic hit_in;  // Both endpoints lie strictly inside the circle.
    logic calc;    // The line meets the circle and roots are to be placed.
    logic single;  // The discriminant is zero, so there is only one root.
  } sci_flags_t;

endpackage

// File: src/sci_if.sv
// Input and output channel interfaces of the segment and circle crossing block.
`timescale 1ns / 1ps

interface sci_in_if import sci_pkg::*; #(
  parameter int COORD_BITS = COORD_BITS_DEF
) ();
  logic                         valid;
  logic                         ready;
  logic signed [COORD_BITS-1:0] start_x;
  logic signed [COORD_BITS-1:0] start_y;
  logic signed [COORD_BITS-1:0] end_x;
  logic signed [COORD_BITS-1:0] end_y;
  logic signed [COORD_BITS-1:0] center_x;
  logic signed [COORD_BITS-1:0] center_y;
  logic        [COORD_BITS-2:0] circle_radius;

  modport source (
    output valid, start_x, start_y, end_x, end_y, center_x, center_y, circle_radius,
    input  ready
  );
  modport sink (
    input  valid, start_x, start_y, end_x, end_y, center_x, center_y, circle_radius,
    output ready
  );
endinterface

interface sci_out_if import sci_pkg::*; #(
  parameter int COORD_BITS = COORD_BITS_DEF
) ();
  logic                         valid;
  logic                         ready;
  logic                         hit;
  logic        [1:0]            point_count;
  logic signed [COORD_BITS-1:0] first_x;
  logic signed [COORD_BITS-1:0] first_y;
  logic signed [COORD_BITS-1:0] second_x;
  logic signed [COORD_BITS-1:0] second_y;

  modport source (
    output valid, hit, point_count, first_x, first_y, second_x, second_y,
    input  ready
  );
  modport sink (
    input  valid, hit, point_count, first_x, first_y, second_x, second_y,
    output ready
  );
endinterface

// File: src/sci_front.sv
// Front end: differences, products, sums, box and inside tests, discriminant.
`timescale 1ns / 1ps

module sci_front import sci_pkg::*; #(
  parameter int COORD_BITS = COORD_BITS_DEF,
  localparam int C  = COORD_BITS,
  localparam int SW = 2 * C + 3,
  localparam int AW = 2 * C + 1,
  localparam int DW = 4 * C
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                en_i,
  input  logic                valid_i,
  input  logic signed [C-1:0] x0_i,
  input  logic signed [C-1:0] y0_i,
  input  logic signed [C-1:0] x1_i,
  input  logic signed [C-1:0] y1_i,
  input  logic signed [C-1:0] cx_i,
  input  logic signed [C-1:0] cy_i,
  input  logic        [C-2:0] r_i,
  output logic                valid_o,
  output logic        [DW-1:0] disc_o,
  output logic signed [SW-1:0] h_o,
  output logic        [AW-1:0] a_o,
  output logic signed [C:0]   dx_o,
  output logic signed [C:0]   dy_o,
  output logic signed [C-1:0] x0_o,
  output logic signed [C-1:0] y0_o,
  output sci_flags_t          flags_o
);

  localparam int ACW  = (SW < CROSS_LIMIT_BITS) ? SW : CROSS_LIMIT_BITS;
  localparam int R2W  = 2 * C - 2;
  localparam int AR2W = AW + R2W;
  localparam int CMPW = (2 * ACW > AR2W) ? 2 * ACW : AR2W;

  logic [4:0] vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[3:0], valid_i};
    end
  end

  // Stage 1: differences and the grown bounding box test.
  logic signed [C+1:0] rad_e, lox, hix, loy, hiy, cxe, cye;
  logic                inbox;

  always_comb begin
    rad_e = signed'((C+2)'(r_i));
    cxe   = (C+2)'(cx_i);
    cye   = (C+2)'(cy_i);
    lox   = ((x0_i < x1_i) ? (C+2)'(x0_i) : (C+2)'(x1_i)) - rad_e;
    hix   = ((x0_i > x1_i) ? (C+2)'(x0_i) : (C+2)'(x1_i)) + rad_e;
    loy   = ((y0_i < y1_i) ? (C+2)'(y0_i) : (C+2)'(y1_i)) - rad_e;
    hiy   = ((y0_i > y1_i) ? (C+2)'(y0_i) : (C+2)'(y1_i)) + rad_e;
    inbox = (cxe >= lox) && (cxe <= hix) && (cye >= loy) && (cye <= hiy);
  end

  logic signed [C:0]   s1_dx_q, s1_dy_q, s1_fx_q, s1_fy_q, s1_gx_q, s1_gy_q;
  logic signed [C-1:0] s1_x0_q, s1_y0_q;
  logic        [C-2:0] s1_r_q;
  logic                s1_inbox_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s1_dx_q    <= (C+1)'(x1_i) - (C+1)'(x0_i);
      s1_dy_q    <= (C+1)'(y1_i) - (C+1)'(y0_i);
      s1_fx_q    <= (C+1)'(x0_i) - (C+1)'(cx_i);
      s1_fy_q    <= (C+1)'(y0_i) - (C+1)'(cy_i);
      s1_gx_q    <= (C+1)'(x1_i) - (C+1)'(cx_i);
      s1_gy_q    <= (C+1)'(y1_i) - (C+1)'(cy_i);
      s1_x0_q    <= x0_i;
      s1_y0_q    <= y0_i;
      s1_r_q     <= r_i;
      s1_inbox_q <= inbox;
    end
  end

  // Stage 2: products of the differences and the squared radius.
  logic signed [2*C+1:0] s2_dxdx_q, s2_dydy_q, s2_fxdx_q, s2_fydy_q, s2_dxfy_q;
  logic signed [2*C+1:0] s2_dyfx_q, s2_fxfx_q, s2_fyfy_q, s2_gxgx_q, s2_gygy_q;
  logic        [R2W-1:0] s2_r2_q;
  logic signed [C:0]     s2_dx_q, s2_dy_q;
  logic signed [C-1:0]   s2_x0_q, s2_y0_q;
  logic                  s2_inbox_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s2_dxdx_q  <= s1_dx_q * s1_dx_q;
      s2_dydy_q  <= s1_dy_q * s1_dy_q;
      s2_fxdx_q  <= s1_fx_q * s1_dx_q;
      s2_fydy_q  <= s1_fy_q * s1_dy_q;
      s2_dxfy_q  <= s1_dx_q * s1_fy_q;
      s2_dyfx_q  <= s1_dy_q * s1_fx_q;
      s2_fxfx_q  <= s1_fx_q * s1_fx_q;
      s2_fyfy_q  <= s1_fy_q * s1_fy_q;
      s2_gxgx_q  <= s1_gx_q * s1_gx_q;
      s2_gygy_q  <= s1_gy_q * s1_gy_q;
      s2_r2_q    <= s1_r_q * s1_r_q;
      s2_dx_q    <= s1_dx_q;
      s2_dy_q    <= s1_dy_q;
      s2_x0_q    <= s1_x0_q;
      s2_y0_q    <= s1_y0_q;
      s2_inbox_q <= s1_inbox_q;
    end
  end

  // Stage 3: dot and cross products, endpoint distances against the radius.
  logic signed [SW-1:0] d0, d1, r2e;

  always_comb begin
    d0  = SW'(s2_fxfx_q) + SW'(s2_fyfy_q);
    d1  = SW'(s2_gxgx_q) + SW'(s2_gygy_q);
    r2e = signed'(SW'(s2_r2_q));
  end

  logic signed [SW-1:0]  s3_a_q, s3_h_q, s3_cr_q;
  logic        [R2W-1:0] s3_r2_q;
  logic signed [C:0]     s3_dx_q, s3_dy_q;
  logic signed [C-1:0]   s3_x0_q, s3_y0_q;
  logic                  s3_inbox_q, s3_inside_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s3_a_q      <= SW'(s2_dxdx_q) + SW'(s2_dydy_q);
      s3_h_q      <= SW'(s2_fxdx_q) + SW'(s2_fydy_q);
      s3_cr_q     <= SW'(s2_dxfy_q) - SW'(s2_dyfx_q);
      s3_r2_q     <= s2_r2_q;
      s3_dx_q     <= s2_dx_q;
      s3_dy_q     <= s2_dy_q;
      s3_x0_q     <= s2_x0_q;
      s3_y0_q     <= s2_y0_q;
      s3_inbox_q  <= s2_inbox_q;
      s3_inside_q <= (d0 < r2e) && (d1 < r2e);
    end
  end

  // Stage 4: squared cross product and squared radius times squared length.
  logic [SW-1:0]  across;
  logic [ACW-1:0] ac;
  logic           ac_ok;

  always_comb begin
    across = s3_cr_q[SW-1] ? unsigned'(-s3_cr_q) : unsigned'(s3_cr_q);
    ac_ok  = (across >> CROSS_LIMIT_BITS) == '0;
    ac     = across[ACW-1:0];
  end

  logic [2*ACW-1:0]     s4_c2_q;
  logic [AR2W-1:0]      s4_ar2_q;
  logic signed [SW-1:0] s4_h_q;
  logic [AW-1:0]        s4_a_q;
  logic signed [C:0]    s4_dx_q, s4_dy_q;
  logic signed [C-1:0]  s4_x0_q, s4_y0_q;
  logic                 s4_ok_q, s4_hit_in_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s4_c2_q     <= ac * ac;
      s4_ar2_q    <= s3_a_q[AW-1:0] * s3_r2_q;
      s4_h_q      <= s3_h_q;
      s4_a_q      <= s3_a_q[AW-1:0];
      s4_dx_q     <= s3_dx_q;
      s4_dy_q     <= s3_dy_q;
      s4_x0_q     <= s3_x0_q;
      s4_y0_q     <= s3_y0_q;
      s4_ok_q     <= s3_inbox_q && !s3_inside_q && (s3_a_q != '0) && ac_ok;
      s4_hit_in_q <= s3_inbox_q && s3_inside_q;
    end
  end

  // Stage 5: discriminant and the root decision.
  logic [CMPW-1:0] c2e, ar2e;

  always_comb begin
    c2e  = CMPW'(s4_c2_q);
    ar2e = CMPW'(s4_ar2_q);
  end

  logic [DW-1:0]        s5_disc_q;
  logic signed [SW-1:0] s5_h_q;
  logic [AW-1:0]        s5_a_q;
  logic signed [C:0]    s5_dx_q, s5_dy_q;
  logic signed [C-1:0]  s5_x0_q, s5_y0_q;
  sci_flags_t           s5_flags_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s5_disc_q         <= DW'(ar2e - c2e);
      s5_h_q            <= s4_h_q;
      s5_a_q            <= s4_a_q;
      s5_dx_q           <= s4_dx_q;
      s5_dy_q           <= s4_dy_q;
      s5_x0_q           <= s4_x0_q;
      s5_y0_q           <= s4_y0_q;
      s5_flags_q.hit_in <= s4_hit_in_q;
      s5_flags_q.calc   <= s4_ok_q && (c2e <= ar2e);
      s5_flags_q.single <= (c2e == ar2e);
    end
  end

  assign valid_o = vld_q[4];
  assign disc_o  = s5_disc_q;
  assign h_o     = s5_h_q;
  assign a_o     = s5_a_q;
  assign dx_o    = s5_dx_q;
  assign dy_o    = s5_dy_q;
  assign x0_o    = s5_x0_q;
  assign y0_o    = s5_y0_q;
  assign flags_o = s5_flags_q;

endmodule

// File: src/sci_sqrt.sv
// Pipelined integer square root, one result bit per stage.
`timescale 1ns / 1ps

module sci_sqrt import sci_pkg::*; #(
  parameter int COORD_BITS = COORD_BITS_DEF,
  parameter int SIDEW      = 1,
  localparam int DW = 4 * COORD_BITS,
  localparam int SB = DW / 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             en_i,
  input  logic             valid_i,
  input  logic [DW-1:0]    rad_i,
  input  logic [SIDEW-1:0] side_i,
  output logic             valid_o,
  output logic [SB-1:0]    root_o,
  output logic [SIDEW-1:0] side_o
);

  logic [SB:0]      vld_q;
  logic [DW-1:0]    rem_q  [SB+1];
  logic [DW-1:0]    res_q  [SB+1];
  logic [SIDEW-1:0] side_q [SB+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[SB-1:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q[0]  <= rad_i;
      res_q[0]  <= '0;
      side_q[0] <= side_i;
    end
  end

  for (genvar i = 0; i < SB; i++) begin : g_step
    localparam logic [DW-1:0] StepBit = {{(DW-1){1'b0}}, 1'b1} << (DW - 2 - 2 * i);
    logic [DW-1:0] trial;
    logic          take;

    always_comb begin
      trial = res_q[i] + StepBit;
      take  = rem_q[i] >= trial;
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[i+1]  <= take ? rem_q[i] - trial : rem_q[i];
        res_q[i+1]  <= take ? (res_q[i] >> 1) + StepBit : res_q[i] >> 1;
        side_q[i+1] <= side_q[i];
      end
    end
  end

  assign valid_o = vld_q[SB];
  assign root_o  = res_q[SB][SB-1:0];
  assign side_o  = side_q[SB];

endmodule

// File: src/sci_div.sv
// Pipelined floor division of point offsets by twice the squared length.
`timescale 1ns / 1ps

module sci_div import sci_pkg::*; #(
  parameter int COORD_BITS = COORD_BITS_DEF,
  parameter int LANES      = 4,
  parameter int SIDEW      = 1,
  localparam int C    = COORD_BITS,
  localparam int AW   = 2 * C + 1,
  localparam int PW   = 3 * C + 5,
  localparam int NUMW = PW + 2,
  localparam int QB   = C + 1
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 en_i,
  input  logic                 valid_i,
  input  logic signed [PW-1:0] prod_i [LANES],
  input  logic        [AW-1:0] area_i,
  input  logic     [SIDEW-1:0] side_i,
  output logic                 valid_o,
  output logic signed [QB:0]   quo_o  [LANES],
  output logic     [SIDEW-1:0] side_o
);

  logic [QB+1:0]     vld_q;
  logic [NUMW-1:0]   mag_q  [QB+1][LANES];
  logic [QB-1:0]     qm_q   [QB+1][LANES];
  logic              neg_q  [QB+1][LANES];
  logic [AW:0]       den_q  [QB+1];
  logic [SIDEW-1:0]  side_q [QB+2];
  logic signed [QB:0] quo_q [LANES];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[QB:0], valid_i};
    end
  end

  // Numerator 2*d*n + a, split into sign and magnitude.
  logic signed [NUMW-1:0] num [LANES];

  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      num[l] = (NUMW'(prod_i[l]) <<< 1) + signed'(NUMW'(area_i));
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int l = 0; l < LANES; l++) begin
        neg_q[0][l] <= num[l][NUMW-1];
        mag_q[0][l] <= num[l][NUMW-1] ? unsigned'(-num[l]) : unsigned'(num[l]);
        qm_q[0][l]  <= '0;
      end
      den_q[0]  <= {area_i, 1'b0};
      side_q[0] <= side_i;
    end
  end

  for (genvar k = 0; k < QB; k++) begin : g_bit
    logic [NUMW-1:0] shifted;
    logic            take [LANES];

    always_comb begin
      shifted = NUMW'(den_q[k]) << (QB - 1 - k);
      for (int l = 0; l < LANES; l++) begin
        take[l] = mag_q[k][l] >= shifted;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        for (int l = 0; l < LANES; l++) begin
          mag_q[k+1][l] <= take[l] ? mag_q[k][l] - shifted : mag_q[k][l];
          qm_q[k+1][l]  <= {qm_q[k][l][QB-2:0], take[l]};
          neg_q[k+1][l] <= neg_q[k][l];
        end
        den_q[k+1]  <= den_q[k];
        side_q[k+1] <= side_q[k];
      end
    end
  end

  // A negative quotient with a remainder rounds one further down.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int l = 0; l < LANES; l++) begin
        quo_q[l] <= neg_q[QB][l]
                  ? -signed'((QB+1)'(qm_q[QB][l])) - signed'((QB+1)'(mag_q[QB][l] != '0))
                  : signed'((QB+1)'(qm_q[QB][l]));
      end
      side_q[QB+1] <= side_q[QB];
    end
  end

  assign valid_o = vld_q[QB+1];
  assign quo_o   = quo_q;
  assign side_o  = side_q[QB+1];

endmodule

// File: src/segment_circle_intersection.sv
// Top level of the segment and circle crossing block.
// The block takes one item per cycle on in_i: a segment given by its start
// and end points, a circle centre and a radius, in millimetres, signed but
// the radius unsigned. For every item it returns exactly one item on out_o:
// a hit flag, the number of crossing points (0 to 2) and the points
// themselves, rounded to the nearest millimetre and ordered by x, then by
// y. Unused point fields are zero.
// Both channels use a valid and ready handshake; an item moves at a rising
// clock edge with valid and ready high. The pipeline holds five front stages,
// 2*COORD_BITS+1 stages of the square root unit, two stages that place the
// roots, COORD_BITS+3 stages of the divider and the output register. Its
// length follows from the square root, which produces one result bit per
// stage.
// Throughput is one item per cycle. Every stage moves on the same enable,
// which is low only while the output register holds an item that the
// receiver does not take; then in_i.ready is low and nothing is lost or
// repeated. Reset clears all valid bits and the output valid.
`timescale 1ns / 1ps

module segment_circle_intersection import sci_pkg::*; #(
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  sci_in_if.sink    in_i,
  sci_out_if.source out_o
);

  localparam int C     = COORD_BITS;
  localparam int SW    = 2 * C + 3;
  localparam int AW    = 2 * C + 1;
  localparam int DW    = 4 * C;
  localparam int SB    = DW / 2;
  localparam int NW    = SW + 1;
  localparam int PW    = 3 * C + 5;
  localparam int QB    = C + 1;
  localparam int SQSW  = SW + AW + 2 * (C + 1) + 2 * C + $bits(sci_flags_t);
  localparam int DVSW  = 2 * C + 3;
  localparam int LANES = 4;

  // The whole pipeline advances unless a finished item waits at the output.
  logic pipe_en;
  logic out_valid_q;

  assign pipe_en    = !out_valid_q || out_o.ready;
  assign in_i.ready = pipe_en;

  // Front end: products, tests and the discriminant.
  logic                fr_valid;
  logic [DW-1:0]       fr_disc;
  logic signed [SW-1:0] fr_h;
  logic [AW-1:0]       fr_a;
  logic signed [C:0]   fr_dx, fr_dy;
  logic signed [C-1:0] fr_x0, fr_y0;
  sci_flags_t          fr_flags;

  sci_front #(
    .COORD_BITS (COORD_BITS)
  ) u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (pipe_en),
    .valid_i (in_i.valid),
    .x0_i    (in_i.start_x),
    .y0_i    (in_i.start_y),
    .x1_i    (in_i.end_x),
    .y1_i    (in_i.end_y),
    .cx_i    (in_i.center_x),
    .cy_i    (in_i.center_y),
    .r_i     (in_i.circle_radius),
    .valid_o (fr_valid),
    .disc_o  (fr_disc),
    .h_o     (fr_h),
    .a_o     (fr_a),
    .dx_o    (fr_dx),
    .dy_o    (fr_dy),
    .x0_o    (fr_x0),
    .y0_o    (fr_y0),
    .flags_o (fr_flags)
  );

  // Square root of the discriminant; the rest of the item rides alongside.
  logic                 sq_valid;
  logic [SB-1:0]        sq_root;
  logic [SQSW-1:0]      sq_side;
  logic signed [SW-1:0] sq_h;
  logic [AW-1:0]        sq_a;
  logic signed [C:0]    sq_dx, sq_dy;
  logic signed [C-1:0]  sq_x0, sq_y0;
  sci_flags_t           sq_flags;

  sci_sqrt #(
    .COORD_BITS (COORD_BITS),
    .SIDEW      (SQSW)
  ) u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (pipe_en),
    .valid_i (fr_valid),
    .rad_i   (fr_disc),
    .side_i  ({fr_h, fr_a, fr_dx, fr_dy, fr_x0, fr_y0, fr_flags}),
    .valid_o (sq_valid),
    .root_o  (sq_root),
    .side_o  (sq_side)
  );

  assign {sq_h, sq_a, sq_dx, sq_dy, sq_x0, sq_y0, sq_flags} = sq_side;

  // Root stage: the two line parameters, scaled by the squared length, and
  // whether each one falls on the segment.
  logic signed [NW-1:0] n0, n1, a_e;
  logic                 ok0, ok1;

  always_comb begin
    n0  = -NW'(sq_h) - signed'(NW'(sq_root));
    n1  = -NW'(sq_h) + signed'(NW'(sq_root));
    a_e = signed'(NW'(sq_a));
    ok0 = sq_flags.calc && (n0 >= 0) && (n0 <= a_e);
    ok1 = sq_flags.calc && !sq_flags.single && (n1 >= 0) && (n1 <= a_e);
  end

  logic                 rt_valid_q;
  logic signed [NW-1:0] rt_n0_q, rt_n1_q;
  logic [AW-1:0]        rt_a_q;
  logic signed [C:0]    rt_dx_q, rt_dy_q;
  logic signed [C-1:0]  rt_x0_q, rt_y0_q;
  logic                 rt_v0_q, rt_v1_q, rt_hit_in_q;

  // Multiply stage: offsets along the segment before the division.
  logic                 mu_valid_q;
  logic signed [PW-1:0] mu_prod_q [LANES];
  logic [AW-1:0]        mu_a_q;
  logic signed [C-1:0]  mu_x0_q, mu_y0_q;
  logic                 mu_v0_q, mu_v1_q, mu_hit_in_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rt_valid_q <= 1'b0;
      mu_valid_q <= 1'b0;
    end else if (pipe_en) begin
      rt_valid_q <= sq_valid;
      mu_valid_q <= rt_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pipe_en) begin
      rt_n0_q      <= n0;
      rt_n1_q      <= n1;
      rt_a_q       <= sq_a;
      rt_dx_q      <= sq_dx;
      rt_dy_q      <= sq_dy;
      rt_x0_q      <= sq_x0;
      rt_y0_q      <= sq_y0;
      rt_v0_q      <= ok0;
      rt_v1_q      <= ok1;
      rt_hit_in_q  <= sq_flags.hit_in;
      mu_prod_q[0] <= rt_dx_q * rt_n0_q;
      mu_prod_q[1] <= rt_dy_q * rt_n0_q;
      mu_prod_q[2] <= rt_dx_q * rt_n1_q;
      mu_prod_q[3] <= rt_dy_q * rt_n1_q;
      mu_a_q       <= rt_a_q;
      mu_x0_q      <= rt_x0_q;
      mu_y0_q      <= rt_y0_q;
      mu_v0_q      <= rt_v0_q;
      mu_v1_q      <= rt_v1_q;
      mu_hit_in_q  <= rt_hit_in_q;
    end
  end

  // Division rounds each offset to the nearest millimetre, halves upward.
  logic                 dv_valid;
  logic signed [QB:0]   dv_quo [LANES];
  logic [DVSW-1:0]      dv_side;
  logic signed [C-1:0]  dv_x0, dv_y0;
  logic                 dv_v0, dv_v1, dv_hit_in;

  sci_div #(
    .COORD_BITS (COORD_BITS),
    .LANES      (LANES),
    .SIDEW      (DVSW)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (pipe_en),
    .valid_i (mu_valid_q),
    .prod_i  (mu_prod_q),
    .area_i  (mu_a_q),
    .side_i  ({mu_x0_q, mu_y0_q, mu_v0_q, mu_v1_q, mu_hit_in_q}),
    .valid_o (dv_valid),
    .quo_o   (dv_quo),
    .side_o  (dv_side)
  );

  assign {dv_x0, dv_y0, dv_v0, dv_v1, dv_hit_in} = dv_side;

  // Final placement and ordering of the points.
  logic signed [C+1:0] px0, py0, px1, py1;
  logic signed [C+1:0] fx, fy, sx, sy;
  logic                swap, both;

  always_comb begin
    px0  = (C+2)'(dv_x0) + (C+2)'(dv_quo[0]);
    py0  = (C+2)'(dv_y0) + (C+2)'(dv_quo[1]);
    px1  = (C+2)'(dv_x0) + (C+2)'(dv_quo[2]);
    py1  = (C+2)'(dv_y0) + (C+2)'(dv_quo[3]);
    both = dv_v0 && dv_v1;
    swap = both && ((px1 < px0) || ((px1 == px0) && (py1 < py0)));
    if (swap || (!dv_v0 && dv_v1)) begin
      fx = px1;
      fy = py1;
    end else if (dv_v0) begin
      fx = px0;
      fy = py0;
    end else begin
      fx = '0;
      fy = '0;
    end
    if (!both) begin
      sx = '0;
      sy = '0;
    end else if (swap) begin
      sx = px0;
      sy = py0;
    end else begin
      sx = px1;
      sy = py1;
    end
  end

  logic                hit_q;
  logic [1:0]          count_q;
  logic signed [C-1:0] first_x_q, first_y_q, second_x_q, second_y_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (pipe_en) begin
      out_valid_q <= dv_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pipe_en) begin
      hit_q      <= dv_hit_in || dv_v0 || dv_v1;
      count_q    <= 2'(dv_v0) + 2'(dv_v1);
      first_x_q  <= fx[C-1:0];
      first_y_q  <= fy[C-1:0];
      second_x_q <= sx[C-1:0];
      second_y_q <= sy[C-1:0];
    end
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.hit         = hit_q;
  assign out_o.point_count = count_q;
  assign out_o.first_x     = first_x_q;
  assign out_o.first_y     = first_y_q;
  assign out_o.second_x    = second_x_q;
  assign out_o.second_y    = second_y_q;

  // A reported point always means a hit.
  a_points_hit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && (count_q != 2'd0) |-> hit_q)
    else $error("points reported without a hit");

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (count_q != 2'd3))
    else $error("point count out of range");

  a_second_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && (count_q != 2'd2) |-> (second_x_q == '0) && (second_y_q == '0))
    else $error("unused second point not zero");

  a_first_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && (count_q == 2'd0) |-> (first_x_q == '0) && (first_y_q == '0))
    else $error("unused first point not zero");

  a_ordered: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && (count_q == 2'd2) |->
      (first_x_q < second_x_q) || ((first_x_q == second_x_q) && (first_y_q <= second_y_q)))
    else $error("points out of order");

endmodule
